>>> rtl/rem_pkg.sv
// shared types, defaults and control codes for the reconstruction error metrics block
package rem_pkg;

    localparam int SAMPLE_BITS_DEF      = 16;
    localparam int MAX_SAMPLES_LOG2_DEF = 24;
    localparam int REL_FRAC_BITS_DEF    = 16;
    localparam int MSE_FRAC_BITS_DEF    = 8;

    // relative error result width, fixed
    localparam int REL_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_START,
        ST_DIV_REL,
        ST_UPDATE,
        ST_MSE_START,
        ST_DIV_MSE,
        ST_OUT
    } rem_state_t;

    typedef enum logic {
        DIV_REL,
        DIV_MSE
    } rem_div_op_t;

    typedef struct packed {
        logic        capture;
        logic        prep;
        logic        square;
        logic        div_start;
        rem_div_op_t div_op;
        logic        update;
        logic        load_out;
        logic        clear;
    } rem_cmd_t;

    typedef struct packed {
        logic last;
        logic nonzero;
        logic div_done;
        logic out_free;
    } rem_status_t;

endpackage

>>> rtl/reconstruction_error_metrics_unit.sv
// top level of the reconstruction error metrics block
//
//  channel | dir | handshake             | contents
//  --------+-----+-----------------------+-------------------------------------------
//  cfg     | in  | cfg_valid / cfg_ready | samples_signed (1 = two's complement)
//  s_      | in  | s_tvalid / s_tready   | original, restored samples; tlast ends a run
//  m_      | out | m_tvalid / m_tready   | all run metrics, one transaction per run
//
//  each pair is captured, its error terms are prepared and squared, its relative
//  error is divided and folded into the run statistics; the radix-2 divider makes
//  the relative error one bit a cycle; a pair with a zero original skips the division
//  the last pair of a run adds the mean division on the same divider and the load
//  synchronous active-low reset clears the run statistics and sets samples_signed to 1
//  one result sits in the output register; pairs of the next run are taken meanwhile,
//  and only the following result load waits on m_tready
module reconstruction_error_metrics_unit #(
    parameter int SAMPLE_BITS      = rem_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_SAMPLES_LOG2 = rem_pkg::MAX_SAMPLES_LOG2_DEF,
    parameter int REL_FRAC_BITS    = rem_pkg::REL_FRAC_BITS_DEF,
    parameter int MSE_FRAC_BITS    = rem_pkg::MSE_FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    // configuration write channel
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data,     // samples_signed

    // sample pairs
    input  logic s_tvalid,
    output logic s_tready,
    // original_sample, restored_sample
    input  logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic s_tlast,      // last_in_run

    // run results
    output logic m_tvalid,
    input  logic m_tready,
    // all_equal, equal_total, pair_total, lowest_original, highest_original,
    // least_abs_error, greatest_abs_error, rel_error_seen, least_rel_error,
    // greatest_rel_error, squared_error_sum, mean_squared_error
    output logic [((8 * SAMPLE_BITS + 3 * MAX_SAMPLES_LOG2 + MSE_FRAC_BITS + 68 + 7) / 8) * 8
                  - 1:0] m_tdata
);

    import rem_pkg::*;

    rem_cmd_t    cmd;
    rem_status_t status;
    logic        cfg_we;

    // the register may be written at any time; writes must only come while idle, the block does not enforce this
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // sequencer: one pair in work at a time
    rem_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    // statistics, shared divider and output register
    rem_datapath #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .MAX_SAMPLES_LOG2(MAX_SAMPLES_LOG2),
        .REL_FRAC_BITS   (REL_FRAC_BITS),
        .MSE_FRAC_BITS   (MSE_FRAC_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tready(m_tready),
        .m_tvalid(m_tvalid),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

>>> rtl/rem_divider.sv
// radix-2 restoring divider, one quotient bit per cycle, top-aligned dividend
module rem_divider #(
    parameter int DVD_W = 72,
    parameter int DVS_W = 25,
    localparam int CNT_W = $clog2(DVD_W + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    input  logic [CNT_W-1:0] steps,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic [DVD_W-1:0] work_reg, work_next;
    logic [DVS_W-1:0] part_reg, part_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    always_comb begin
        trial     = {part_reg, work_reg[DVD_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        work_next = work_reg;
        part_next = part_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            work_next = dividend;
            part_next = '0;
            dvs_next  = divisor;
            cnt_next  = steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            part_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            work_next = {work_reg[DVD_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        part_reg <= part_next;
        dvs_reg  <= dvs_next;
    end

    // last step happens this cycle, quotient is complete after the edge
    assign done     = busy_reg && (cnt_reg == CNT_W'(1));
    assign quotient = work_reg;

endmodule

>>> rtl/rem_datapath.sv
// datapath: sample registers, error terms, run statistics, divider and result register
module rem_datapath #(
    parameter int SAMPLE_BITS      = 16,
    parameter int MAX_SAMPLES_LOG2 = 24,
    parameter int REL_FRAC_BITS    = 16,
    parameter int MSE_FRAC_BITS    = 8,
    localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((8 * SAMPLE_BITS + 3 * MAX_SAMPLES_LOG2 + MSE_FRAC_BITS + 68 + 7)
                            / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_data,
    input  logic [IN_W-1:0]      s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [OUT_W-1:0]     m_tdata,
    input  rem_pkg::rem_cmd_t    cmd,
    output rem_pkg::rem_status_t status
);

    import rem_pkg::*;

    localparam int SB         = SAMPLE_BITS;
    localparam int ML         = MAX_SAMPLES_LOG2;
    localparam int CNT_W      = ML + 1;
    localparam int SQ_W       = 2 * SB + ML;
    localparam int MSE_W      = 2 * SB + MSE_FRAC_BITS;
    localparam int REL_STEPS  = SB + REL_FRAC_BITS;
    localparam int MSE_STEPS  = SQ_W + MSE_FRAC_BITS;
    localparam int DVD_W      = (REL_STEPS > MSE_STEPS) ? REL_STEPS : MSE_STEPS;
    localparam int DVS_W      = (SB > CNT_W) ? SB : CNT_W;
    localparam int DIV_CNT_W  = $clog2(DVD_W + 1);
    localparam int QX_W       = (DVD_W > REL_W) ? DVD_W : REL_W + 1;

    // config
    logic samples_signed_reg;

    // per-pair work registers
    logic [SB-1:0]   o_reg, r_reg;
    logic            last_reg;
    logic [SB-1:0]   diff_reg, mag_reg;
    logic            nz_reg, eq_reg;
    logic [2*SB-1:0] d2_reg;

    // run statistics
    logic [CNT_W-1:0] eq_cnt_reg, eq_cnt_next;
    logic [CNT_W-1:0] pair_cnt_reg, pair_cnt_next;
    logic [SB-1:0]    min_orig_reg, min_orig_next;
    logic [SB-1:0]    max_orig_reg, max_orig_next;
    logic [SB-1:0]    min_abs_reg, min_abs_next;
    logic [SB-1:0]    max_abs_reg, max_abs_next;
    logic [REL_W-1:0] min_rel_reg, min_rel_next;
    logic [REL_W-1:0] max_rel_reg, max_rel_next;
    logic             rel_seen_reg, rel_seen_next;
    logic [SQ_W-1:0]  sq_acc_reg, sq_acc_next;
    logic             mismatch_reg, mismatch_next;

    // result register
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg;

    // combinational terms
    logic signed [SB:0] o_val, r_val, min_val, max_val;
    logic [SB+1:0]      diff_s, diff_m;
    logic [SB:0]        o_mag;
    logic [SQ_W:0]      sq_sum;
    logic [SB-1:0]      orig_lo_init, orig_hi_init;

    // divider
    logic [DVD_W-1:0]     div_dvd, div_quo;
    logic [DVS_W-1:0]     div_dvs;
    logic [DIV_CNT_W-1:0] div_steps;
    logic                 div_done;
    logic [QX_W-1:0]      quo_x;
    logic [REL_W-1:0]     rel_sat;
    logic [MSE_W-1:0]     mse_sat;

    assign o_val   = $signed({samples_signed_reg & o_reg[SB-1], o_reg});
    assign r_val   = $signed({samples_signed_reg & r_reg[SB-1], r_reg});
    assign min_val = $signed({samples_signed_reg & min_orig_reg[SB-1], min_orig_reg});
    assign max_val = $signed({samples_signed_reg & max_orig_reg[SB-1], max_orig_reg});

    assign diff_s = {o_val[SB], o_val} - {r_val[SB], r_val};
    assign diff_m = diff_s[SB+1] ? (~diff_s + 1'b1) : diff_s;
    assign o_mag  = o_val[SB] ? (~o_val + 1'b1) : o_val;

    assign sq_sum = {1'b0, sq_acc_reg} + (SQ_W + 1)'(d2_reg);

    assign orig_lo_init = samples_signed_reg ? {1'b0, {(SB - 1){1'b1}}} : '1;
    assign orig_hi_init = samples_signed_reg ? {1'b1, {(SB - 1){1'b0}}} : '0;

    // operands are placed at the top of the shift register, steps cover their bits plus the fraction bits
    always_comb begin
        if (cmd.div_op == DIV_MSE) begin
            div_dvd   = DVD_W'(sq_acc_reg) << (DVD_W - SQ_W);
            div_dvs   = DVS_W'(pair_cnt_reg);
            div_steps = DIV_CNT_W'(MSE_STEPS);
        end else begin
            div_dvd   = DVD_W'(diff_reg) << (DVD_W - SB);
            div_dvs   = DVS_W'(mag_reg);
            div_steps = DIV_CNT_W'(REL_STEPS);
        end
    end

    rem_divider #(
        .DVD_W(DVD_W),
        .DVS_W(DVS_W)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .dividend(div_dvd),
        .divisor (div_dvs),
        .steps   (div_steps),
        .done    (div_done),
        .quotient(div_quo)
    );

    assign quo_x   = QX_W'(div_quo);
    assign rel_sat = (|quo_x[QX_W-1:REL_W]) ? '1 : quo_x[REL_W-1:0];
    assign mse_sat = (|quo_x[QX_W-1:MSE_W]) ? '1 : quo_x[MSE_W-1:0];

    always_comb begin
        eq_cnt_next   = eq_cnt_reg;
        pair_cnt_next = pair_cnt_reg;
        min_orig_next = min_orig_reg;
        max_orig_next = max_orig_reg;
        min_abs_next  = min_abs_reg;
        max_abs_next  = max_abs_reg;
        min_rel_next  = min_rel_reg;
        max_rel_next  = max_rel_reg;
        rel_seen_next = rel_seen_reg;
        sq_acc_next   = sq_acc_reg;
        mismatch_next = mismatch_reg;
        if (cmd.clear) begin
            eq_cnt_next   = '0;
            pair_cnt_next = '0;
            min_orig_next = orig_lo_init;
            max_orig_next = orig_hi_init;
            min_abs_next  = '1;
            max_abs_next  = '0;
            min_rel_next  = '1;
            max_rel_next  = '0;
            rel_seen_next = 1'b0;
            sq_acc_next   = '0;
            mismatch_next = 1'b0;
        end else if (cmd.update) begin
            if (eq_reg) begin
                if (!eq_cnt_reg[ML]) begin
                    eq_cnt_next = eq_cnt_reg + 1'b1;
                end
            end else begin
                mismatch_next = 1'b1;
            end
            // first pair of a run loads both extremes
            if (pair_cnt_reg == '0) begin
                min_orig_next = o_reg;
                max_orig_next = o_reg;
            end else begin
                if (o_val < min_val) begin
                    min_orig_next = o_reg;
                end
                if (o_val > max_val) begin
                    max_orig_next = o_reg;
                end
            end
            if (diff_reg < min_abs_reg) begin
                min_abs_next = diff_reg;
            end
            if (diff_reg > max_abs_reg) begin
                max_abs_next = diff_reg;
            end
            if (nz_reg) begin
                if (rel_sat < min_rel_reg) begin
                    min_rel_next = rel_sat;
                end
                if (rel_sat > max_rel_reg) begin
                    max_rel_next = rel_sat;
                end
                rel_seen_next = 1'b1;
            end
            sq_acc_next = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
            if (!pair_cnt_reg[ML]) begin
                pair_cnt_next = pair_cnt_reg + 1'b1;
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            samples_signed_reg <= 1'b1;
            eq_cnt_reg         <= '0;
            pair_cnt_reg       <= '0;
            min_orig_reg       <= {1'b0, {(SB - 1){1'b1}}};
            max_orig_reg       <= {1'b1, {(SB - 1){1'b0}}};
            min_abs_reg        <= '1;
            max_abs_reg        <= '0;
            min_rel_reg        <= '1;
            max_rel_reg        <= '0;
            rel_seen_reg       <= 1'b0;
            sq_acc_reg         <= '0;
            mismatch_reg       <= 1'b0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                samples_signed_reg <= cfg_data;
            end
            eq_cnt_reg   <= eq_cnt_next;
            pair_cnt_reg <= pair_cnt_next;
            min_orig_reg <= min_orig_next;
            max_orig_reg <= max_orig_next;
            min_abs_reg  <= min_abs_next;
            max_abs_reg  <= max_abs_next;
            min_rel_reg  <= min_rel_next;
            max_rel_reg  <= max_rel_next;
            rel_seen_reg <= rel_seen_next;
            sq_acc_reg   <= sq_acc_next;
            mismatch_reg <= mismatch_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            o_reg    <= s_tdata[SB-1:0];
            r_reg    <= s_tdata[2*SB-1:SB];
            last_reg <= s_tlast;
        end
        if (cmd.prep) begin
            diff_reg <= diff_m[SB-1:0];
            mag_reg  <= o_mag[SB-1:0];
            nz_reg   <= |o_reg;
            eq_reg   <= (o_reg == r_reg);
        end
        if (cmd.square) begin
            d2_reg <= diff_reg * diff_reg;
        end
        if (cmd.load_out) begin
            m_tdata_reg <= OUT_W'({mse_sat,
                                   sq_acc_reg,
                                   rel_seen_reg ? max_rel_reg : {REL_W{1'b0}},
                                   rel_seen_reg ? min_rel_reg : {REL_W{1'b0}},
                                   rel_seen_reg,
                                   max_abs_reg,
                                   min_abs_reg,
                                   max_orig_reg,
                                   min_orig_reg,
                                   pair_cnt_reg,
                                   eq_cnt_reg,
                                   !mismatch_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign status.last     = last_reg;
    assign status.nonzero  = nz_reg;
    assign status.div_done = div_done;
    assign status.out_free = !m_tvalid_reg || m_tready;

    a_eq_within_pairs: assert property (@(posedge aclk) disable iff (!aresetn)
        eq_cnt_reg <= pair_cnt_reg)
        else $error("equal count above pair count");

    a_all_equal_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        !mismatch_reg |-> (eq_cnt_reg == pair_cnt_reg))
        else $error("no mismatch seen but counts differ");

    a_rel_idle_values: assert property (@(posedge aclk) disable iff (!aresetn)
        !rel_seen_reg |-> (min_rel_reg == '1 && max_rel_reg == '0))
        else $error("relative extremes moved without a nonzero original");

endmodule

>>> rtl/rem_ctrl.sv
// controller: sequences capture, error terms, divisions, update and result load
module rem_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  rem_pkg::rem_status_t status,
    output rem_pkg::rem_cmd_t    cmd
);

    import rem_pkg::*;

    rem_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = ST_START;
            end
            ST_START: begin
                state_next = status.nonzero ? ST_DIV_REL : ST_UPDATE;
            end
            ST_DIV_REL: begin
                if (status.div_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = status.last ? ST_MSE_START : ST_IDLE;
            end
            ST_MSE_START: begin
                state_next = ST_DIV_MSE;
            end
            ST_DIV_MSE: begin
                if (status.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_PREP: begin
                cmd.prep = 1'b1;
            end
            ST_START: begin
                cmd.square    = 1'b1;
                cmd.div_start = status.nonzero;
                cmd.div_op    = DIV_REL;
            end
            ST_DIV_REL: begin
                cmd.div_op = DIV_REL;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
            end
            ST_MSE_START: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_MSE;
            end
            ST_DIV_MSE: begin
                cmd.div_op = DIV_MSE;
            end
            ST_OUT: begin
                cmd.load_out = status.out_free;
                cmd.clear    = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_done_while_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == ST_DIV_REL || state_reg == ST_DIV_MSE))
        else $error("divider finished outside a wait state");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("result loaded over an unclaimed result");

    a_one_pair_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second pair accepted while one is in work");

endmodule
